/* rtl/lict_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lict_pkg
// Shared types and constants for the local interrupt controller timer subset.
// ----------------------------------------------------------------------------
package lict_pkg;

  localparam int COUNTER_WIDTH_DEF = 32;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register offsets
  localparam logic [9:0] OFF_EOI    = 10'h0b0;
  localparam logic [9:0] OFF_SPUR   = 10'h0f0;
  localparam logic [9:0] OFF_ICR_LO = 10'h300;
  localparam logic [9:0] OFF_ICR_HI = 10'h310;
  localparam logic [9:0] OFF_LVT    = 10'h320;
  localparam logic [9:0] OFF_INIT   = 10'h380;
  localparam logic [9:0] OFF_CUR    = 10'h390;
  localparam logic [9:0] OFF_DIV    = 10'h3e0;

  // register field masks
  localparam logic [17:0] LVT_KEEP     = 18'h300ff;
  localparam logic [17:0] LVT_RESET    = 18'h10000;
  localparam int          LVT_MASK_BIT = 16;
  localparam int          LVT_PER_BIT  = 17;
  localparam int          SPUR_EN_BIT  = 8;
  localparam logic [3:0]  DIV_KEEP     = 4'hb;
  localparam logic [31:0] ICR_KEEP     = 32'hffffefff;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  reg_offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        timer_interrupt;
    logic [7:0]  interrupt_vector;
    logic        ipi_send;
    logic [7:0]  ipi_destination;
    logic [7:0]  ipi_vector;
  } out_item_t;

endpackage

/* rtl/lict_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lict_core
// Architectural registers, timer prescaler and counter, and the result logic
// for one item; state advances on each transfer through the stage.
// ----------------------------------------------------------------------------
module lict_core
  import lict_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t res
);

  localparam int CW = COUNTER_WIDTH;

  logic [8:0]    spur_r,    spur_nxt;
  logic [17:0]   lvt_r,     lvt_nxt;
  logic [CW-1:0] init_r,    init_nxt;
  logic [CW-1:0] cur_r,     cur_nxt;
  logic [3:0]    div_r,     div_nxt;
  logic [6:0]    presc_r,   presc_nxt;
  logic [7:0]    target_r,  target_nxt;
  logic [31:0]   icr_lo_r,  icr_lo_nxt;

  logic [2:0]    div_shift;
  logic [6:0]    period;
  logic [6:0]    presc_inc;
  logic [CW-1:0] cur_dec;
  logic          step;

  assign div_shift = {div_r[3], div_r[1:0]} + 3'd1;
  assign period    = (7'd1 << div_shift) - 7'd1;
  assign presc_inc = presc_r + 7'd1;
  assign cur_dec   = cur_r - {{(CW-1){1'b0}}, 1'b1};
  assign step      = ((presc_inc & period) == 7'd0) && (cur_r != '0);

  always_comb begin
    spur_nxt   = spur_r;
    lvt_nxt    = lvt_r;
    init_nxt   = init_r;
    cur_nxt    = cur_r;
    div_nxt    = div_r;
    presc_nxt  = presc_r;
    target_nxt = target_r;
    icr_lo_nxt = icr_lo_r;
    res        = '0;
    case (item.command)
      CMD_TICK: begin
        presc_nxt = presc_inc;
        if (step) begin
          cur_nxt = cur_dec;
          if (cur_dec == '0) begin
            if (!lvt_r[LVT_MASK_BIT] && spur_r[SPUR_EN_BIT]) begin
              res.timer_interrupt  = 1'b1;
              res.interrupt_vector = lvt_r[7:0];
            end
            if (lvt_r[LVT_PER_BIT]) begin
              cur_nxt = init_r;
            end
          end
        end
      end
      CMD_WRITE: begin
        case (item.reg_offset)
          OFF_SPUR:   spur_nxt = item.write_data[8:0];
          OFF_ICR_LO: begin
            icr_lo_nxt          = item.write_data & ICR_KEEP;
            res.ipi_send        = 1'b1;
            res.ipi_destination = target_r;
            res.ipi_vector      = item.write_data[7:0];
          end
          OFF_ICR_HI: target_nxt = item.write_data[31:24];
          OFF_LVT:    lvt_nxt = item.write_data[17:0] & LVT_KEEP;
          OFF_INIT: begin
            init_nxt  = item.write_data[CW-1:0];
            cur_nxt   = item.write_data[CW-1:0];
            presc_nxt = 7'd0;
          end
          OFF_DIV:    div_nxt = item.write_data[3:0] & DIV_KEEP;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (item.reg_offset)
          OFF_EOI:    res.read_data = 32'd0;
          OFF_SPUR:   res.read_data = 32'(spur_r);
          OFF_ICR_LO: res.read_data = icr_lo_r;
          OFF_ICR_HI: res.read_data = {target_r, 24'd0};
          OFF_LVT:    res.read_data = 32'(lvt_r);
          OFF_INIT:   res.read_data = 32'(init_r);
          OFF_CUR:    res.read_data = 32'(cur_r);
          OFF_DIV:    res.read_data = 32'(div_r);
          default:    res.read_data = 32'd0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spur_r   <= '0;
      lvt_r    <= LVT_RESET;
      init_r   <= '0;
      cur_r    <= '0;
      div_r    <= '0;
      presc_r  <= '0;
      target_r <= '0;
      icr_lo_r <= '0;
    end else if (fire) begin
      spur_r   <= spur_nxt;
      lvt_r    <= lvt_nxt;
      init_r   <= init_nxt;
      cur_r    <= cur_nxt;
      div_r    <= div_nxt;
      presc_r  <= presc_nxt;
      target_r <= target_nxt;
      icr_lo_r <= icr_lo_nxt;
    end
  end

endmodule

/* rtl/local_interrupt_controller_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_interrupt_controller_timer
// Local interrupt controller subset: timer with prescaler, LVT, spurious
// enable and IPI send through the ICR, driven by tick, write and read items.
//
//   port group | dir | payload     | handshake
//   in_        | in  | in_item_t   | in_valid / in_stall
//   out_       | out | out_item_t  | out_valid / out_stall
//
// One item per cycle sustained while out_stall is low; a result passes the
// input register, then the result register, with the register file between.
// Reset is synchronous; it clears the controller state but sets the LVT mask bit.
// A stalled result holds; the input register keeps one item behind it and
// in_stall rises only when both registers are full and out_stall is high.
// ----------------------------------------------------------------------------
module local_interrupt_controller_timer
  import lict_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t res;
  logic      out_free;
  logic      fire;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  lict_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (in_item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // a timer result never carries read data or an ipi
  a_tint_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timer_interrupt |->
      !out_data.ipi_send && (out_data.read_data == 32'd0))
    else $error("timer interrupt mixed with other result fields");

  // vectors only show with their event
  a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.timer_interrupt |-> (out_data.interrupt_vector == 8'd0))
    else $error("timer vector without interrupt");

  // input side stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register free");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

/* verif/tb_local_interrupt_controller_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_local_interrupt_controller_timer
// Self-checking bench for the timer and IPI subset. A directed register walk
// comes first, then weighted random ticks, writes and reads under four idle
// and stall mixes. Every result transfer is checked field by field against a
// fixed row result or an in-bench model of prescaler, counter and registers.
// ----------------------------------------------------------------------------
module tb_local_interrupt_controller_timer;
  import lict_pkg::*;

  localparam int         CW         = COUNTER_WIDTH_DEF;
  localparam int         LIMIT      = 200000;
  localparam int         RAND_ITEMS = 112;
  localparam int         HOLD_LEN   = 80;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  bit        exp_typed;
  out_item_t exp_fixed;
  out_item_t expected_results[$];
  dir_row_t  directed[$];
  int        errors;
  int        cycles;
  int        idle_pct;
  int        stall_pct;
  bit        hold_req;
  int        hold_cnt;

  logic [8:0]  spur_reg;
  logic [17:0] lvt_reg;
  logic [31:0] init_count;
  logic [31:0] cur_count;
  logic [3:0]  div_cfg;
  logic [6:0]  prescale;
  logic [7:0]  icr_target;
  logic [31:0] icr_low;

  local_interrupt_controller_timer #(
    .COUNTER_WIDTH(CW)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  function automatic out_item_t lapic_result(in_item_t it);
    out_item_t   r;
    logic [2:0]  shift;
    logic [6:0]  period;
    logic [31:0] cmask;
    r = '0;
    cmask = 32'((64'd1 << CW) - 64'd1);
    case (it.command)
      CMD_TICK: begin
        shift = {div_cfg[3], div_cfg[1:0]} + 3'd1;
        period = 7'((8'd1 << shift) - 8'd1);
        prescale = prescale + 7'd1;
        if ((prescale & period) == 7'd0 && cur_count != 32'd0) begin
          cur_count = (cur_count - 32'd1) & cmask;
          if (cur_count == 32'd0) begin
            if (!lvt_reg[LVT_MASK_BIT] && spur_reg[SPUR_EN_BIT]) begin
              r.timer_interrupt = 1'b1;
              r.interrupt_vector = lvt_reg[7:0];
            end
            if (lvt_reg[LVT_PER_BIT]) cur_count = init_count;
          end
        end
      end
      CMD_WRITE: begin
        case (it.reg_offset)
          OFF_SPUR:   spur_reg = it.write_data[8:0];
          OFF_ICR_LO: begin
            icr_low = it.write_data & ICR_KEEP;
            r.ipi_send = 1'b1;
            r.ipi_destination = icr_target;
            r.ipi_vector = it.write_data[7:0];
          end
          OFF_ICR_HI: icr_target = it.write_data[31:24];
          OFF_LVT:    lvt_reg = it.write_data[17:0] & LVT_KEEP;
          OFF_INIT: begin
            init_count = it.write_data & cmask;
            cur_count = init_count;
            prescale = '0;
          end
          OFF_DIV:    div_cfg = it.write_data[3:0] & DIV_KEEP;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (it.reg_offset)
          OFF_SPUR:   r.read_data = {23'd0, spur_reg};
          OFF_ICR_LO: r.read_data = icr_low;
          OFF_ICR_HI: r.read_data = {icr_target, 24'd0};
          OFF_LVT:    r.read_data = {14'd0, lvt_reg};
          OFF_INIT:   r.read_data = init_count;
          OFF_CUR:    r.read_data = cur_count;
          OFF_DIV:    r.read_data = {28'd0, div_cfg};
          default:    r.read_data = '0;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] known_offset();
    logic [9:0] o;
    case ($urandom_range(7, 0))
      0:       o = OFF_EOI;
      1:       o = OFF_SPUR;
      2:       o = OFF_ICR_LO;
      3:       o = OFF_ICR_HI;
      4:       o = OFF_LVT;
      5:       o = OFF_INIT;
      6:       o = OFF_CUR;
      default: o = OFF_DIV;
    endcase
    return o;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    it.command = CMD_TICK;
    it.reg_offset = 10'($urandom);
    it.write_data = $urandom;
    if (pick >= 55 && pick < 80) begin
      it.command = CMD_WRITE;
      it.reg_offset = known_offset();
      // short counts so the timer expires often
      if (it.reg_offset == OFF_INIT && $urandom_range(3, 0) != 0)
        it.write_data = $urandom_range(12, 0);
      if (it.reg_offset == OFF_LVT && $urandom_range(3, 0) != 0)
        it.write_data[LVT_MASK_BIT] = 1'b0;
      if (it.reg_offset == OFF_SPUR && $urandom_range(3, 0) != 0)
        it.write_data[SPUR_EN_BIT] = 1'b1;
    end else if (pick >= 80 && pick < 95) begin
      it.command = CMD_READ;
      it.reg_offset = known_offset();
    end else if (pick >= 95) begin
      it.command = 2'($urandom);
    end
    return it;
  endfunction

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, e, a);
    end
  endfunction

  task automatic row(logic [1:0] cmd, logic [9:0] off, logic [31:0] data, bit typed,
                     out_item_t res);
    dir_row_t d;
    d.item.command = cmd;
    d.item.reg_offset = off;
    d.item.write_data = data;
    d.typed = typed;
    d.res = res;
    directed.push_back(d);
  endtask

  task automatic send(in_item_t it, bit typed, out_item_t res);
    while ($urandom_range(99, 0) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    exp_typed <= typed;
    exp_fixed <= res;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver side: random stall plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  // input transfers feed the model
  always @(posedge clk) begin
    out_item_t r;
    if (rst_n && in_valid && !in_stall) begin
      r = lapic_result(in_data);
      expected_results.push_back(exp_typed ? exp_fixed : r);
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h", $time, out_data);
      end else begin
        e = expected_results.pop_front();
        check_field("read_data", e.read_data, out_data.read_data);
        check_field("timer_interrupt", 32'(e.timer_interrupt),
                    32'(out_data.timer_interrupt));
        check_field("interrupt_vector", 32'(e.interrupt_vector),
                    32'(out_data.interrupt_vector));
        check_field("ipi_send", 32'(e.ipi_send), 32'(out_data.ipi_send));
        check_field("ipi_destination", 32'(e.ipi_destination),
                    32'(out_data.ipi_destination));
        check_field("ipi_vector", 32'(e.ipi_vector), 32'(out_data.ipi_vector));
      end
    end
  end

  initial begin
    int ph;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    exp_typed = 1'b0;
    exp_fixed = '0;
    hold_req = 1'b0;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    spur_reg = '0;
    lvt_reg = LVT_RESET;
    init_count = '0;
    cur_count = '0;
    div_cfg = '0;
    prescale = '0;
    icr_target = '0;
    icr_low = '0;

    row(CMD_READ,  OFF_LVT,    32'h0,         1'b1, {32'h0001_0000, 26'd0});
    // stopped timer
    row(CMD_TICK,  OFF_EOI,    32'h0,         1'b1, '0);
    row(CMD_WRITE, OFF_SPUR,   32'hffff_ffff, 1'b1, '0);
    row(CMD_READ,  OFF_SPUR,   32'h0,         1'b1, {32'h0000_01ff, 26'd0});
    row(CMD_WRITE, OFF_ICR_HI, 32'hffff_ffff, 1'b1, '0);
    row(CMD_READ,  OFF_ICR_HI, 32'h0,         1'b1, {32'hff00_0000, 26'd0});
    row(CMD_WRITE, OFF_ICR_LO, 32'hffff_ffff, 1'b1,
        {32'h0, 1'b0, 8'h00, 1'b1, 8'hff, 8'hff});
    // delivery status reads 0
    row(CMD_READ,  OFF_ICR_LO, 32'h0,         1'b1, {32'hffff_efff, 26'd0});
    row(CMD_WRITE, OFF_LVT,    32'hfffe_ffff, 1'b1, '0);
    row(CMD_READ,  OFF_LVT,    32'h0,         1'b1, {32'h0002_00ff, 26'd0});
    row(CMD_WRITE, OFF_DIV,    32'hffff_ffff, 1'b1, '0);
    row(CMD_READ,  OFF_DIV,    32'h0,         1'b1, {32'h0000_000b, 26'd0});
    // divide by one, periodic reload
    row(CMD_WRITE, OFF_INIT,   32'h2,         1'b0, '0);
    row(CMD_TICK,  OFF_CUR,    32'hffff_ffff, 1'b0, '0);
    row(CMD_TICK,  OFF_CUR,    32'h0,         1'b1,
        {32'h0, 1'b1, 8'hff, 1'b0, 8'h00, 8'h00});
    // read-only and write-only registers
    row(CMD_WRITE, OFF_CUR,    32'h1234_5678, 1'b0, '0);
    row(CMD_WRITE, OFF_EOI,    32'hffff_ffff, 1'b0, '0);
    row(CMD_READ,  OFF_EOI,    32'h0,         1'b1, '0);
    row(CMD_READ,  10'h3ff,    32'hffff_ffff, 1'b1, '0);
    row(CMD_WRITE, 10'h000,    32'hffff_ffff, 1'b0, '0);
    row(CMD_NONE,  OFF_CUR,    32'hffff_ffff, 1'b1, '0);
    // disabled controller: expiry without delivery, IPI still sent
    row(CMD_WRITE, OFF_SPUR,   32'h0,         1'b0, '0);
    row(CMD_TICK,  OFF_EOI,    32'h0,         1'b0, '0);
    row(CMD_TICK,  OFF_EOI,    32'h0,         1'b0, '0);
    row(CMD_WRITE, OFF_INIT,   32'hffff_ffff, 1'b0, '0);
    row(CMD_READ,  OFF_CUR,    32'h0,         1'b1, {32'hffff_ffff, 26'd0});
    row(CMD_WRITE, OFF_ICR_LO, 32'h0,         1'b1,
        {32'h0, 1'b0, 8'h00, 1'b1, 8'hff, 8'h00});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].res);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 46;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 46;
        end
        default: begin
          idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      for (n = 0; n < RAND_ITEMS; n++) begin
        if (ph == 0 && n == 20) hold_req = 1'b1;
        send(random_item(), 1'b0, '0);
      end
      drain();
    end

    if (errors == 0 && expected_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/lict_pkg.sv
rtl/lict_core.sv
rtl/local_interrupt_controller_timer.sv
verif/tb_local_interrupt_controller_timer.sv
